>>> rtl/btpc_pkg.sv
// ---------------------------------------------------------------------------
// btpc_pkg
// Types and constants shared by the pressure compensation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package btpc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AC1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC4   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AC5   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AC6   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd7;

    localparam logic [31:0] K_B6_OFS  = 32'd4000;
    localparam logic [31:0] K_X3_OFS  = 32'd32768;
    localparam logic [31:0] K_B7_BASE = 32'd50000;
    localparam logic [31:0] K_P_C1    = 32'd3038;
    localparam logic [31:0] K_P_C2    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] K_P_C3    = 32'd3791;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_press;
    } t_req;

    typedef struct packed {
        logic signed [31:0] temp_tenths;
        logic signed [31:0] press_pa;
        logic               div_fault;
    } t_rsp;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } t_cal;

    // Low 32 bits of a product.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        return 32'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

>>> rtl/btpc_div.sv
// ---------------------------------------------------------------------------
// btpc_div
// Pipelined restoring divider: 32-bit unsigned magnitude, one quotient bit
// per stage, user tag carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_div import btpc_pkg::*; #(
    parameter int unsigned TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [31:0]      i_num,
    input  wire logic [31:0]      i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_vld,
    output logic [31:0]           o_quo,
    output logic [TAG_W-1:0]      o_tag
);
    localparam int unsigned N = 32;

    logic             r_vld [N];
    logic [31:0]      r_rem [N];
    logic [31:0]      r_quo [N];
    logic [31:0]      r_den [N];
    logic [TAG_W-1:0] r_tag [N];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[k-1];
            end
        end
    end

    // One quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            logic [32:0] rem_in;
            logic [31:0] quo_in;
            logic [31:0] den_in;
            logic [32:0] diff;
            den_in = (k == 0) ? i_den : r_den[k-1];
            quo_in = (k == 0) ? i_num : r_quo[k-1];
            rem_in = {((k == 0) ? 32'd0 : r_rem[k-1]), quo_in[31]};
            diff   = rem_in - {1'b0, den_in};
            if (!diff[32]) begin
                r_rem[k] <= diff[31:0];
                r_quo[k] <= {quo_in[30:0], 1'b1};
            end else begin
                r_rem[k] <= rem_in[31:0];
                r_quo[k] <= {quo_in[30:0], 1'b0};
            end
            r_den[k] <= den_in;
            r_tag[k] <= (k == 0) ? i_tag : r_tag[k-1];
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_quo = r_quo[N-1];
    assign o_tag = r_tag[N-1];
endmodule
`default_nettype wire

>>> rtl/btpc_cfg.sv
// ---------------------------------------------------------------------------
// btpc_cfg
// Calibration register file with sign decode of the packed coefficients.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_cfg import btpc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cal                       o_cal
);
    logic [15:0] r_ac [6];
    logic [31:0] r_b1_b2;
    logic [31:0] r_mc_md;

    // Hold calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_ac[k] <= '0;
            r_b1_b2 <= '0;
            r_mc_md <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AC1:   r_ac[0] <= i_cfg_data[15:0];
                REG_AC2:   r_ac[1] <= i_cfg_data[15:0];
                REG_AC3:   r_ac[2] <= i_cfg_data[15:0];
                REG_AC4:   r_ac[3] <= i_cfg_data[15:0];
                REG_AC5:   r_ac[4] <= i_cfg_data[15:0];
                REG_AC6:   r_ac[5] <= i_cfg_data[15:0];
                REG_B1_B2: r_b1_b2 <= i_cfg_data;
                REG_MC_MD: r_mc_md <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cal.ac1 = r_ac[0];
    assign o_cal.ac2 = r_ac[1];
    assign o_cal.ac3 = r_ac[2];
    assign o_cal.ac4 = r_ac[3];
    assign o_cal.ac5 = r_ac[4];
    assign o_cal.ac6 = r_ac[5];
    assign o_cal.b1  = r_b1_b2[31:16];
    assign o_cal.b2  = r_b1_b2[15:0];
    assign o_cal.mc  = r_mc_md[31:16];
    assign o_cal.md  = r_mc_md[15:0];
endmodule
`default_nettype wire

>>> rtl/baro_temp_pressure_compensate.sv
// ---------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Integer barometric temperature and pressure compensation pipeline.
//
//   channel  | ports                          | handshake
//   request  | i_start, i_req, o_busy         | taken when i_start && !o_busy
//   result   | o_done, o_rsp                  | one-cycle strobe, no stall
//   config   | i_cfg_we, i_cfg_idx, i_cfg_data| write on i_cfg_we
//
// One request per cycle; o_busy is held low. Each request passes through the
// two 32-stage pipelined restoring dividers (temperature correction x2 and
// pressure b7/b4) plus eleven arithmetic stages.
// Reset clears every valid bit; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none
module baro_temp_pressure_compensate import btpc_pkg::*; #(
    parameter int unsigned OVERSAMPLING = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_req                  i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output t_rsp                       o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [31:0] B7_MUL = K_B7_BASE >> OVERSAMPLING;

    t_cal cal;

    btpc_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_cal(cal)
    );

    assign o_busy = 1'b0;

    // ---------------- stage A: x1 product
    logic        r_a_vld;
    logic [31:0] r_a_prod;
    logic [18:0] r_a_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else          r_a_vld <= i_start;
        r_a_prod <= mul32({16'd0, i_req.raw_temp} - {16'd0, cal.ac6}, {16'd0, cal.ac5});
        r_a_up   <= i_req.raw_press;
    end

    // ---------------- stage B: x1, divisor, numerator sign split
    logic        r_b_vld;
    logic [31:0] r_b_x1;
    logic [31:0] r_b_num;
    logic [31:0] r_b_den;
    logic        r_b_neg;
    logic        r_b_zero;
    logic [18:0] r_b_up;
    always_ff @(posedge i_clk) begin
        logic [31:0] x1, den, num;
        x1  = asr32(r_a_prod, 15);
        den = x1 + {{16{cal.md[15]}}, cal.md};
        num = {{16{cal.mc[15]}}, cal.mc} << 11;
        if (!i_rst_n) r_b_vld <= 1'b0;
        else          r_b_vld <= r_a_vld;
        r_b_x1   <= x1;
        r_b_num  <= num[31] ? -num : num;
        r_b_den  <= den[31] ? -den : den;
        r_b_neg  <= num[31] ^ den[31];
        r_b_zero <= (den == 32'd0);
        r_b_up   <= r_a_up;
    end

    // ---------------- temperature divider
    localparam int unsigned TT_W = 32 + 1 + 1 + 19;
    logic            td_vld;
    logic [31:0]     td_quo;
    logic [TT_W-1:0] td_tag;
    btpc_div #(.TAG_W(TT_W)) u_tdiv (
        .i_clk, .i_rst_n,
        .i_vld(r_b_vld), .i_num(r_b_num), .i_den(r_b_den),
        .i_tag({r_b_x1, r_b_neg, r_b_zero, r_b_up}),
        .o_vld(td_vld), .o_quo(td_quo), .o_tag(td_tag)
    );

    // ---------------- stage C: b5, t, b6
    logic        r_c_vld;
    logic [31:0] r_c_t, r_c_b6;
    logic        r_c_zero;
    logic [18:0] r_c_up;
    always_ff @(posedge i_clk) begin
        logic [31:0] x2, b5;
        x2 = td_tag[TT_W-33] ? -td_quo : td_quo;
        b5 = td_tag[TT_W-1 -: 32] + x2;
        if (!i_rst_n) r_c_vld <= 1'b0;
        else          r_c_vld <= td_vld;
        r_c_t    <= asr32(b5 + 32'd8, 4);
        r_c_b6   <= b5 - K_B6_OFS;
        r_c_zero <= td_tag[19];
        r_c_up   <= td_tag[18:0];
    end

    // ---------------- stage D: b6 products
    logic        r_d_vld;
    logic [31:0] r_d_t, r_d_sq, r_d_ac2b6, r_d_ac3b6;
    logic        r_d_zero;
    logic [18:0] r_d_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else          r_d_vld <= r_c_vld;
        r_d_sq    <= asr32(mul32(r_c_b6, r_c_b6), 12);
        r_d_ac2b6 <= mul32({{16{cal.ac2[15]}}, cal.ac2}, r_c_b6);
        r_d_ac3b6 <= mul32({{16{cal.ac3[15]}}, cal.ac3}, r_c_b6);
        r_d_t     <= r_c_t;
        r_d_zero  <= r_c_zero;
        r_d_up    <= r_c_up;
    end

    // ---------------- stage E: sq products
    logic        r_e_vld;
    logic [31:0] r_e_t, r_e_b2sq, r_e_b1sq, r_e_ac2b6, r_e_ac3b6;
    logic        r_e_zero;
    logic [18:0] r_e_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else          r_e_vld <= r_d_vld;
        r_e_b2sq  <= mul32({{16{cal.b2[15]}}, cal.b2}, r_d_sq);
        r_e_b1sq  <= mul32({{16{cal.b1[15]}}, cal.b1}, r_d_sq);
        r_e_ac2b6 <= r_d_ac2b6;
        r_e_ac3b6 <= r_d_ac3b6;
        r_e_t     <= r_d_t;
        r_e_zero  <= r_d_zero;
        r_e_up    <= r_d_up;
    end

    // ---------------- stage F: b3 and x3 sums
    logic        r_f_vld;
    logic [31:0] r_f_t, r_f_b3, r_f_x3;
    logic        r_f_zero;
    logic [18:0] r_f_up;
    always_ff @(posedge i_clk) begin
        logic [31:0] x3a, v, x3b;
        x3a = asr32(r_e_b2sq, 11) + asr32(r_e_ac2b6, 11);
        v   = ((({{16{cal.ac1[15]}}, cal.ac1} << 2) + x3a) << OVERSAMPLING) + 32'd2;
        // x3: arithmetic shift floors; b3 below: signed divide by 4 truncates toward zero
        x3b = asr32(asr32(r_e_ac3b6, 13) + asr32(r_e_b1sq, 16) + 32'd2, 2);
        if (!i_rst_n) r_f_vld <= 1'b0;
        else          r_f_vld <= r_e_vld;
        r_f_b3   <= asr32(v + (v[31] ? 32'd3 : 32'd0), 2);
        r_f_x3   <= x3b + K_X3_OFS;
        r_f_t    <= r_e_t;
        r_f_zero <= r_e_zero;
        r_f_up   <= r_e_up;
    end

    // ---------------- stage G: b4 product and up - b3
    logic        r_g_vld;
    logic [31:0] r_g_t, r_g_b4p, r_g_upb3;
    logic        r_g_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_vld <= 1'b0;
        else          r_g_vld <= r_f_vld;
        r_g_b4p  <= mul32({16'd0, cal.ac4}, r_f_x3);
        r_g_upb3 <= {13'd0, r_f_up} - r_f_b3;
        r_g_t    <= r_f_t;
        r_g_zero <= r_f_zero;
    end

    // ---------------- stage H: b7 and divider operands
    logic        r_h_vld;
    logic [31:0] r_h_t, r_h_num, r_h_b4;
    logic        r_h_big;
    logic        r_h_zero;
    always_ff @(posedge i_clk) begin
        logic [31:0] b7;
        b7 = mul32(r_g_upb3, B7_MUL);
        if (!i_rst_n) r_h_vld <= 1'b0;
        else          r_h_vld <= r_g_vld;
        r_h_b4   <= r_g_b4p >> 15;
        r_h_big  <= b7[31];
        r_h_num  <= b7[31] ? b7 : (b7 << 1);
        r_h_t    <= r_g_t;
        r_h_zero <= r_g_zero || ((r_g_b4p >> 15) == 32'd0);
    end

    // ---------------- pressure divider
    localparam int unsigned PT_W = 32 + 1 + 1;
    logic            pd_vld;
    logic [31:0]     pd_quo;
    logic [PT_W-1:0] pd_tag;
    btpc_div #(.TAG_W(PT_W)) u_pdiv (
        .i_clk, .i_rst_n,
        .i_vld(r_h_vld), .i_num(r_h_num), .i_den(r_h_b4),
        .i_tag({r_h_t, r_h_big, r_h_zero}),
        .o_vld(pd_vld), .o_quo(pd_quo), .o_tag(pd_tag)
    );

    // ---------------- stage I: p and its square
    logic        r_i_vld;
    logic [31:0] r_i_t, r_i_p, r_i_pp;
    logic        r_i_zero;
    always_ff @(posedge i_clk) begin
        logic [31:0] p, ps;
        p  = pd_tag[1] ? (pd_quo << 1) : pd_quo;
        ps = asr32(p, 8);
        if (!i_rst_n) r_i_vld <= 1'b0;
        else          r_i_vld <= pd_vld;
        r_i_p    <= p;
        r_i_pp   <= mul32(ps, ps);
        r_i_t    <= pd_tag[PT_W-1 -: 32];
        r_i_zero <= pd_tag[0];
    end

    // ---------------- stage J: correction products
    logic        r_j_vld;
    logic [31:0] r_j_t, r_j_p, r_j_x1, r_j_x2;
    logic        r_j_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_j_vld <= 1'b0;
        else          r_j_vld <= r_i_vld;
        r_j_x1   <= mul32(r_i_pp, K_P_C1);
        r_j_x2   <= mul32(K_P_C2, r_i_p);
        r_j_p    <= r_i_p;
        r_j_t    <= r_i_t;
        r_j_zero <= r_i_zero;
    end

    // ---------------- stage K: final pressure, fault gating
    logic r_k_vld;
    t_rsp r_k_rsp;
    always_ff @(posedge i_clk) begin
        logic [31:0] p;
        p = r_j_p + asr32(asr32(r_j_x1, 16) + asr32(r_j_x2, 16) + K_P_C3, 4);
        if (!i_rst_n) r_k_vld <= 1'b0;
        else          r_k_vld <= r_j_vld;
        r_k_rsp.temp_tenths <= r_j_zero ? 32'sd0 : $signed(r_j_t);
        r_k_rsp.press_pa    <= r_j_zero ? 32'sd0 : $signed(p);
        r_k_rsp.div_fault   <= r_j_zero;
    end

    assign o_done = r_k_vld;
    assign o_rsp  = r_k_rsp;
endmodule
`default_nettype wire

>>> rtl/btpc_chk.sv
// ---------------------------------------------------------------------------
// btpc_chk
// Port-level checks for the compensation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_chk import btpc_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);
    // Fault results carry zero payload
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.div_fault |-> o_rsp.temp_tenths == 0 && o_rsp.press_pa == 0)
        else $error("fault result with nonzero payload");

    // Never refuse a request
    a_no_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result after reset");

    // No result in the cycle that reset is released
    a_no_spur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_done)
        else $error("spurious result");
endmodule

bind baro_temp_pressure_compensate btpc_chk u_chk (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_rsp
);
`default_nettype wire
